// File: design/multiword_multiply_macros.svh
// Assertion macros shared by the multiword multiplier modules.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef MULTIWORD_MULTIPLY_MACROS_SVH
`define MULTIWORD_MULTIPLY_MACROS_SVH

// A property that must hold at every sampled edge.
`define MWM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// A condition that, once seen, must be followed by another in the next cycle.
`define MWM_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

// File: design/mwm_pkg.sv
// ----------------------------------------------------------------------------
// mwm_pkg
// Sizes and controller/datapath interface types of the multiword multiplier.
// ----------------------------------------------------------------------------
package mwm_pkg;

  localparam int WORDS      = 8;
  localparam int WORD_W     = 64;
  localparam int HALF_W     = WORD_W / 2;
  localparam int PROD_WORDS = 2 * WORDS;
  localparam int IDX_W      = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int COL_W      = $clog2(PROD_WORDS);
  // A column holds up to WORDS full products plus the carry of the column below.
  localparam int ACC_W      = 2 * WORD_W + IDX_W + 1;

  typedef struct packed {
    logic             load;      // store an operand pair
    logic             issue;     // start one partial product
    logic [IDX_W-1:0] a_idx;     // left word index, also the load address
    logic [IDX_W-1:0] b_idx;     // right word index
    logic             zero;      // flush term: force the product to zero
    logic             col_end;   // last term of the column
    logic [COL_W-1:0] col;       // product word the column settles
    logic             emit;      // read one product word into the output
    logic [COL_W-1:0] rd_addr;   // product word to read
    logic             last;      // the word read is the least significant
  } mwm_cmd_t;

  typedef struct packed {
    logic pipe_busy;   // partial products still in flight
    logic out_ready;   // output register can take a word this cycle
  } mwm_status_t;

endpackage

// File: design/mwm_datapath.sv
// ----------------------------------------------------------------------------
// mwm_datapath
// Operand stores, pipelined 64x64 multiplier, column accumulator, product
// store and output register.
// ----------------------------------------------------------------------------
`include "multiword_multiply_macros.svh"

module mwm_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mwm_pkg::mwm_cmd_t           cmd_i,
  output mwm_pkg::mwm_status_t        status_o,
  input  logic [mwm_pkg::WORD_W-1:0]  lhs_word_i,
  input  logic [mwm_pkg::WORD_W-1:0]  rhs_word_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [mwm_pkg::WORD_W-1:0]  product_word_o,
  output logic                        last_word_o
);

  // Operand stores are indexed by weight, index 0 least significant.
  logic [mwm_pkg::WORD_W-1:0] left_mem  [mwm_pkg::WORDS];
  logic [mwm_pkg::WORD_W-1:0] right_mem [mwm_pkg::WORDS];
  logic [mwm_pkg::WORD_W-1:0] prod_mem  [mwm_pkg::PROD_WORDS];

  // Stage 1: operand read.
  logic [mwm_pkg::WORD_W-1:0] a_q, b_q;
  logic                       v1_q, zero1_q, end1_q;
  logic [mwm_pkg::COL_W-1:0]  col1_q;
  // Stage 2: four half-width products.
  logic [mwm_pkg::WORD_W-1:0] pp_hh_q, pp_hl_q, pp_lh_q, pp_ll_q;
  logic [mwm_pkg::WORD_W-1:0] pp_hh_d, pp_hl_d, pp_lh_d, pp_ll_d;
  logic [mwm_pkg::HALF_W-1:0] a_hi, a_lo, b_hi, b_lo;
  logic                       v2_q, end2_q;
  logic [mwm_pkg::COL_W-1:0]  col2_q;
  // Stage 3: full 128-bit product.
  logic [2*mwm_pkg::WORD_W-1:0] full_q, full_d;
  logic                         v3_q, end3_q;
  logic [mwm_pkg::COL_W-1:0]    col3_q;
  // Stage 4: column accumulator.
  logic [mwm_pkg::ACC_W-1:0]  acc_q, acc_d, sum;
  // Output register.
  logic                       out_valid_q;
  logic [mwm_pkg::WORD_W-1:0] word_q;
  logic                       last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      left_mem[cmd_i.a_idx]  <= lhs_word_i;
      right_mem[cmd_i.a_idx] <= rhs_word_i;
    end
    if (cmd_i.issue) begin
      a_q <= left_mem[cmd_i.a_idx];
      b_q <= right_mem[cmd_i.b_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    zero1_q <= cmd_i.zero;
    end1_q  <= cmd_i.col_end;
    col1_q  <= cmd_i.col;
  end

  // The flush term carries no product; its left operand is masked to zero.
  assign a_hi = zero1_q ? '0 : a_q[mwm_pkg::WORD_W-1:mwm_pkg::HALF_W];
  assign a_lo = zero1_q ? '0 : a_q[mwm_pkg::HALF_W-1:0];
  assign b_hi = b_q[mwm_pkg::WORD_W-1:mwm_pkg::HALF_W];
  assign b_lo = b_q[mwm_pkg::HALF_W-1:0];

  assign pp_hh_d = mwm_pkg::WORD_W'(a_hi) * mwm_pkg::WORD_W'(b_hi);
  assign pp_hl_d = mwm_pkg::WORD_W'(a_hi) * mwm_pkg::WORD_W'(b_lo);
  assign pp_lh_d = mwm_pkg::WORD_W'(a_lo) * mwm_pkg::WORD_W'(b_hi);
  assign pp_ll_d = mwm_pkg::WORD_W'(a_lo) * mwm_pkg::WORD_W'(b_lo);

  always_ff @(posedge clk_i) begin
    pp_hh_q <= pp_hh_d;
    pp_hl_q <= pp_hl_d;
    pp_lh_q <= pp_lh_d;
    pp_ll_q <= pp_ll_d;
    end2_q  <= end1_q;
    col2_q  <= col1_q;
  end

  assign full_d = {pp_hh_q, pp_ll_q}
                + {{mwm_pkg::HALF_W{1'b0}}, pp_hl_q, {mwm_pkg::HALF_W{1'b0}}}
                + {{mwm_pkg::HALF_W{1'b0}}, pp_lh_q, {mwm_pkg::HALF_W{1'b0}}};

  always_ff @(posedge clk_i) begin
    full_q <= full_d;
    end3_q <= end2_q;
    col3_q <= col2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // At a column end the low word is final and the rest carries upward.
  assign sum = acc_q + mwm_pkg::ACC_W'(full_q);

  always_comb begin
    acc_d = acc_q;
    if (cmd_i.load) begin
      acc_d = '0;
    end else if (v3_q) begin
      acc_d = end3_q ? (sum >> mwm_pkg::WORD_W) : sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (v3_q && end3_q) begin
      prod_mem[col3_q] <= sum[mwm_pkg::WORD_W-1:0];
    end
    if (cmd_i.emit) begin
      word_q <= prod_mem[cmd_i.rd_addr];
      last_q <= cmd_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign status_o.pipe_busy = v1_q | v2_q | v3_q;
  assign status_o.out_ready = !out_valid_q || !out_stall_i;

  assign out_valid_o    = out_valid_q;
  assign product_word_o = word_q;
  assign last_word_o    = last_q;

  // The top product word must absorb every carry.
  `MWM_ASSERT(a_no_lost_carry, (v3_q && end3_q && (col3_q == mwm_pkg::COL_W'(mwm_pkg::PROD_WORDS - 1))) |-> (sum[mwm_pkg::ACC_W-1:mwm_pkg::WORD_W] == '0), "carry left over after the top product word")
  `MWM_ASSERT(a_emit_after_drain, cmd_i.emit |-> !status_o.pipe_busy, "product read while partial products are in flight")

endmodule

// File: design/mwm_controller.sv
// ----------------------------------------------------------------------------
// mwm_controller
// Sequences loading, column-wise partial product issue, drain and readout.
// ----------------------------------------------------------------------------
`include "multiword_multiply_macros.svh"

module mwm_controller (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  output mwm_pkg::mwm_cmd_t     cmd_o,
  input  mwm_pkg::mwm_status_t  status_i
);

  typedef enum logic [3:0] {
    ST_LOAD  = 4'b0001,
    ST_MUL   = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_OUT   = 4'b1000
  } mwm_state_e;

  mwm_state_e                state_q, state_d;
  logic [mwm_pkg::IDX_W-1:0] load_cnt_q, load_cnt_d;
  logic [mwm_pkg::IDX_W-1:0] row_q, row_d;
  logic [mwm_pkg::COL_W-1:0] col_q, col_d;
  logic [mwm_pkg::COL_W-1:0] out_cnt_q, out_cnt_d;
  logic [mwm_pkg::COL_W-1:0] col_nxt;
  logic [mwm_pkg::IDX_W-1:0] row_max, row_min_nxt;
  logic                      flush_col;

  // Column c takes left word i and right word c-i over the valid rows.
  assign row_max     = (col_q < mwm_pkg::COL_W'(mwm_pkg::WORDS))
                     ? mwm_pkg::IDX_W'(col_q) : mwm_pkg::IDX_W'(mwm_pkg::WORDS - 1);
  assign col_nxt     = col_q + 1'b1;
  assign row_min_nxt = (col_nxt >= mwm_pkg::COL_W'(mwm_pkg::WORDS))
                     ? mwm_pkg::IDX_W'(col_nxt - mwm_pkg::COL_W'(mwm_pkg::WORDS - 1)) : '0;
  // The top column holds no partial product; it only settles the final carry.
  assign flush_col   = (col_q == mwm_pkg::COL_W'(mwm_pkg::PROD_WORDS - 1));

  always_comb begin
    state_d    = state_q;
    load_cnt_d = load_cnt_q;
    row_d      = row_q;
    col_d      = col_q;
    out_cnt_d  = out_cnt_q;
    in_stall_o = 1'b1;

    cmd_o         = '0;
    cmd_o.a_idx   = mwm_pkg::IDX_W'(mwm_pkg::WORDS - 1) - load_cnt_q;
    cmd_o.rd_addr = out_cnt_q;
    cmd_o.last    = (out_cnt_q == '0);
    cmd_o.col     = col_q;

    unique case (state_q)
      ST_LOAD: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
        if (in_valid_i) begin
          if (load_cnt_q == mwm_pkg::IDX_W'(mwm_pkg::WORDS - 1)) begin
            load_cnt_d = '0;
            row_d      = '0;
            col_d      = '0;
            state_d    = ST_MUL;
          end else begin
            load_cnt_d = load_cnt_q + 1'b1;
          end
        end
      end
      ST_MUL: begin
        cmd_o.issue   = 1'b1;
        cmd_o.a_idx   = row_q;
        cmd_o.b_idx   = mwm_pkg::IDX_W'(col_q - mwm_pkg::COL_W'(row_q));
        cmd_o.zero    = flush_col;
        cmd_o.col_end = flush_col || (row_q == row_max);
        if (cmd_o.col_end) begin
          if (flush_col) begin
            state_d = ST_DRAIN;
          end else begin
            col_d = col_nxt;
            row_d = row_min_nxt;
          end
        end else begin
          row_d = row_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!status_i.pipe_busy) begin
          out_cnt_d = mwm_pkg::COL_W'(mwm_pkg::PROD_WORDS - 1);
          state_d   = ST_OUT;
        end
      end
      ST_OUT: begin
        cmd_o.emit = status_i.out_ready;
        if (status_i.out_ready) begin
          if (cmd_o.last) begin
            state_d = ST_LOAD;
          end else begin
            out_cnt_d = out_cnt_q - 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      load_cnt_q <= '0;
      row_q      <= '0;
      col_q      <= '0;
      out_cnt_q  <= '0;
    end else begin
      state_q    <= state_d;
      load_cnt_q <= load_cnt_d;
      row_q      <= row_d;
      col_q      <= col_d;
      out_cnt_q  <= out_cnt_d;
    end
  end

  `MWM_ASSERT_NEXT(a_flush_to_drain, (cmd_o.issue && flush_col), (state_q == ST_DRAIN), "flush column did not end the issue phase")
  `MWM_ASSERT_NEXT(a_last_to_load, (cmd_o.emit && cmd_o.last), (state_q == ST_LOAD && load_cnt_q == '0), "readout did not return to loading")

endmodule

// File: design/multiword_multiply.sv
// A new operation loads only after the readout of the last one; loading, multiply and drain,
// and readout run in turn, the multiply phase set by the one 64x64 multiplier taking one
// word pair per cycle. A finished word may wait while the next loads.
// Reset is asynchronous and active low; it returns the block to loading with no beat pending.
// ----------------------------------------------------------------------------
// multiword_multiply
// Unsigned multiword schoolbook multiplier, product words out most significant first.
// ----------------------------------------------------------------------------
module multiword_multiply (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [mwm_pkg::WORD_W-1:0]  lhs_word_i,
  input  logic [mwm_pkg::WORD_W-1:0]  rhs_word_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [mwm_pkg::WORD_W-1:0]  product_word_o,
  output logic                        last_word_o
);

  mwm_pkg::mwm_cmd_t    cmd;
  mwm_pkg::mwm_status_t status;

  mwm_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  mwm_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .lhs_word_i     (lhs_word_i),
    .rhs_word_i     (rhs_word_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .product_word_o (product_word_o),
    .last_word_o    (last_word_o)
  );

endmodule

// File: sim/tb_multiword_multiply.sv
// ----------------------------------------------------------------------------
// tb_multiword_multiply
// Checks the multiword multiplier against its own schoolbook product model.
// Operand pairs go in with random gaps, and the product beats come back under
// random stall, including one long hold-off. Each product beat is compared
// with the next expected word and last flag.
// ----------------------------------------------------------------------------
module tb_multiword_multiply;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES =
    2 * (mwm_pkg::WORDS * mwm_pkg::WORDS + 6 + mwm_pkg::PROD_WORDS);
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned RANDOM_OPS = 35;

  typedef struct packed {
    logic [mwm_pkg::WORD_W-1:0] lhs;
    logic [mwm_pkg::WORD_W-1:0] rhs;
  } operand_pair_t;

  typedef struct packed {
    logic [mwm_pkg::WORD_W-1:0] word;
    logic                       last;
  } product_beat_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic [mwm_pkg::WORD_W-1:0] lhs_word_i = '0;
  logic [mwm_pkg::WORD_W-1:0] rhs_word_i = '0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic [mwm_pkg::WORD_W-1:0] product_word_o;
  logic                       last_word_o;

  operand_pair_t pending_pairs[$];
  product_beat_t expected_beats[$];

  // Operand words seen by the model, index 0 most significant.
  logic [mwm_pkg::WORD_W-1:0] lhs_words[mwm_pkg::WORDS];
  logic [mwm_pkg::WORD_W-1:0] rhs_words[mwm_pkg::WORDS];
  int unsigned                pairs_loaded = 0;

  int unsigned mismatches = 0;
  int unsigned beats_seen = 0;
  logic        wind_down = 1'b0;

  multiword_multiply u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .lhs_word_i     (lhs_word_i),
    .rhs_word_i     (rhs_word_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .product_word_o (product_word_o),
    .last_word_o    (last_word_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Stores one operand pair; the pair that completes an operation queues
  // the full product, most significant word first.
  task automatic absorb_operand_pair(input logic [mwm_pkg::WORD_W-1:0] lhs,
                                     input logic [mwm_pkg::WORD_W-1:0] rhs);
    logic [mwm_pkg::PROD_WORDS*mwm_pkg::WORD_W-1:0] product;
    logic [mwm_pkg::PROD_WORDS*mwm_pkg::WORD_W-1:0] term;
    product_beat_t                                  beat;
    lhs_words[pairs_loaded] = lhs;
    rhs_words[pairs_loaded] = rhs;
    pairs_loaded++;
    if (pairs_loaded == mwm_pkg::WORDS) begin
      pairs_loaded = 0;
      product = '0;
      for (int i = 0; i < mwm_pkg::WORDS; i++) begin
        for (int j = 0; j < mwm_pkg::WORDS; j++) begin
          term = '0;
          term[2*mwm_pkg::WORD_W-1:0] = {{mwm_pkg::WORD_W{1'b0}}, lhs_words[i]} *
                                        {{mwm_pkg::WORD_W{1'b0}}, rhs_words[j]};
          product += term << (mwm_pkg::WORD_W *
                              ((mwm_pkg::WORDS - 1 - i) + (mwm_pkg::WORDS - 1 - j)));
        end
      end
      for (int k = 0; k < mwm_pkg::PROD_WORDS; k++) begin
        beat.word = product[(mwm_pkg::PROD_WORDS - 1 - k) * mwm_pkg::WORD_W +: mwm_pkg::WORD_W];
        beat.last = (k == mwm_pkg::PROD_WORDS - 1);
        expected_beats.push_back(beat);
      end
    end
  endtask

  function automatic logic [mwm_pkg::WORD_W-1:0] pick_word();
    int unsigned bit_pos;
    logic [mwm_pkg::WORD_W-1:0] one_hot;
    bit_pos = $urandom_range(0, mwm_pkg::WORD_W - 1);
    one_hot = '0;
    one_hot[bit_pos] = 1'b1;
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return one_hot;
      3: return ~one_hot;
      4: return mwm_pkg::WORD_W'($urandom_range(0, 255));
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // Sender: offers queued pairs, with bursts of idle cycles.
  operand_pair_t tx_pair;
  int unsigned   tx_gap_left = 0;
  int unsigned   tx_phase_left = 0;
  int unsigned   tx_idle_pct = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      lhs_word_i <= '0;
      rhs_word_i <= '0;
      wind_down  <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        absorb_operand_pair(lhs_word_i, rhs_word_i);
      end
      if (tx_phase_left == 0) begin
        tx_phase_left = $urandom_range(20, 120);
        tx_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
      end else begin
        tx_phase_left--;
      end
      wind_down <= (pending_pairs.size() < 4 * mwm_pkg::WORDS);
      // A beat on offer stays put until it is taken.
      if (!in_valid_i || !in_stall_o) begin
        if (tx_gap_left > 0) begin
          tx_gap_left--;
          in_valid_i <= 1'b0;
        end else if (!wind_down && tx_idle_pct != 0 &&
                     $urandom_range(0, 99) < tx_idle_pct) begin
          tx_gap_left = $urandom_range(0, 15);
          in_valid_i <= 1'b0;
        end else if (pending_pairs.size() > 0) begin
          tx_pair = pending_pairs.pop_front();
          in_valid_i <= 1'b1;
          lhs_word_i <= tx_pair.lhs;
          rhs_word_i <= tx_pair.rhs;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off after the second
  // product so that the next operation backs up into the input.
  int unsigned rx_gap_left = 0;
  int unsigned rx_phase_left = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (rx_phase_left == 0) begin
        rx_phase_left = $urandom_range(20, 120);
        rx_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
      end else begin
        rx_phase_left--;
      end
      if (!hold_done && beats_seen >= 2 * mwm_pkg::PROD_WORDS) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (rx_gap_left > 0) begin
        rx_gap_left--;
        out_stall_i <= 1'b1;
      end else if (!wind_down && rx_idle_pct != 0 &&
                   $urandom_range(0, 99) < rx_idle_pct) begin
        rx_gap_left = $urandom_range(0, 15);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Monitor: every accepted product beat against the oldest expectation.
  product_beat_t want;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      beats_seen <= beats_seen + 1;
      if (expected_beats.size() == 0) begin
        $error("unexpected product beat: product_word %h last_word %b",
               product_word_o, last_word_o);
        mismatches++;
      end else begin
        want = expected_beats.pop_front();
        if (product_word_o !== want.word) begin
          $error("product_word: expected %h, actual %h", want.word, product_word_o);
          mismatches++;
        end
        if (last_word_o !== want.last) begin
          $error("last_word: expected %b, actual %b", want.last, last_word_o);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles in which neither side moves a beat.
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles == IDLE_LIMIT) begin
        $error("no beat moved for %0d cycles", IDLE_LIMIT);
        $display("multiword_multiply test failed");
        $finish;
      end
    end
  end

  initial begin
    operand_pair_t pair;
    // Maximum carry chain: all ones times all ones.
    for (int w = 0; w < mwm_pkg::WORDS; w++) begin
      pair.lhs = '1;
      pair.rhs = '1;
      pending_pairs.push_back(pair);
    end
    // Zero left operand against an all-ones right operand.
    for (int w = 0; w < mwm_pkg::WORDS; w++) begin
      pair.lhs = '0;
      pair.rhs = '1;
      pending_pairs.push_back(pair);
    end
    // Alternating bit patterns, with a one in the bottom left word and the top right word.
    for (int w = 0; w < mwm_pkg::WORDS; w++) begin
      pair.lhs = (w == mwm_pkg::WORDS - 1) ? mwm_pkg::WORD_W'(1)
                                           : {mwm_pkg::WORD_W/4{4'hA}};
      pair.rhs = (w == 0) ? mwm_pkg::WORD_W'(1) : {mwm_pkg::WORD_W/4{4'h5}};
      pending_pairs.push_back(pair);
    end
    for (int op = 0; op < RANDOM_OPS; op++) begin
      for (int w = 0; w < mwm_pkg::WORDS; w++) begin
        pair.lhs = pick_word();
        pair.rhs = pick_word();
        pending_pairs.push_back(pair);
      end
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // The watchdog bounds both waits.
    while (pending_pairs.size() > 0 || in_valid_i) @(negedge clk_i);
    while (expected_beats.size() > 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (expected_beats.size() > 0) begin
      $error("%0d product beats never arrived", expected_beats.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("multiword_multiply test passed");
    end else begin
      $display("multiword_multiply test failed");
    end
    $finish;
  end

endmodule
